// File: hw/rtl/tbls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_pkg: shared types and constants of the two-root block log sieve
// Field widths, command codes and the word types passed between modules.
// ----------------------------------------------------------------------------
package tbls_pkg;

    localparam int CMD_W    = 2;
    localparam int ROOT_W   = 16;
    localparam int WEIGHT_W = 8;
    localparam int INDEX_W  = 15;
    localparam int BYTE_W   = 8;
    // Position width: a root below 2^16 plus a prime below 2^16.
    localparam int POS_W    = 17;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SIEVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [ROOT_W-1:0]   prime_value;
        logic [ROOT_W-1:0]   first_root;
        logic [ROOT_W-1:0]   second_root;
        logic [WEIGHT_W-1:0] log_weight;
        logic [INDEX_W-1:0]  read_index;
    } tbls_cmd_t;

    typedef struct packed {
        logic [ROOT_W-1:0] next_first_root;
        logic [ROOT_W-1:0] next_second_root;
        logic              skipped;
        logic [BYTE_W-1:0] read_byte;
    } tbls_result_t;

endpackage

// File: hw/rtl/tbls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/tbls_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_step_unit: shared position adder and block compare
// Steps a position by an increment, tests it against the block size and
// forms the position wrapped back by one block.
// ----------------------------------------------------------------------------
module tbls_step_unit
    import tbls_pkg::*;
#(
    parameter int BLOCK_SIZE = 32768
) (
    input  logic [POS_W-1:0]  pos,
    input  logic [ROOT_W-1:0] incr,
    output logic [POS_W-1:0]  pos_step,
    output logic              in_block,
    output logic [ROOT_W-1:0] wrapped
);

    localparam logic [POS_W-1:0] BLOCK_POS = POS_W'(BLOCK_SIZE);

    logic [POS_W-1:0] diff;

    assign pos_step = pos + {1'b0, incr};
    assign in_block = (pos < BLOCK_POS);
    assign diff     = pos - BLOCK_POS;
    assign wrapped  = diff[ROOT_W-1:0];

endmodule

// File: hw/rtl/tbls_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbls_engine: sieve sequencer
// Runs clear sweeps, root striking with read-modify-write of the sieve
// RAM, and byte reads, all through the one shared step unit.
// ----------------------------------------------------------------------------
module tbls_engine
    import tbls_pkg::*;
#(
    parameter int BLOCK_SIZE = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tbls_cmd_t           cmd,
    input  logic [BYTE_W-1:0]   init_value,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_ready,
    output tbls_result_t        res
);

    localparam int ADDR_W = $clog2(BLOCK_SIZE);
    localparam int HIT_W  = $clog2(BLOCK_SIZE + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_SV_RD   = 3'd2;
    localparam logic [2:0] ST_SV_WR   = 3'd3;
    localparam logic [2:0] ST_RD_ADDR = 3'd4;
    localparam logic [2:0] ST_RD_DATA = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]          state_reg,    state_next;
    logic [POS_W-1:0]    pos_reg,      pos_next;
    logic [ROOT_W-1:0]   prime_reg,    prime_next;
    logic [ROOT_W-1:0]   root2_reg,    root2_next;
    logic [WEIGHT_W-1:0] weight_reg,   weight_next;
    logic [HIT_W-1:0]    hits_reg,     hits_next;
    logic [HIT_W-1:0]    hits1_reg,    hits1_next;
    logic [ROOT_W-1:0]   next1_reg,    next1_next;
    logic                root_sel_reg, root_sel_next;
    logic                rd_hit_reg,   rd_hit_next;
    tbls_result_t        res_reg,      res_next;

    logic [ROOT_W-1:0]   incr;
    logic [POS_W-1:0]    pos_step;
    logic                in_block;
    logic [ROOT_W-1:0]   wrapped;

    logic                ram_wr_en;
    logic [BYTE_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [BYTE_W-1:0]   ram_rd_data;
    logic [ADDR_W-1:0]   ram_addr;

    assign incr     = (state_reg == ST_CLEAR) ? ROOT_W'(1) : prime_reg;
    assign ram_addr = pos_reg[ADDR_W-1:0];

    tbls_step_unit #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_step (
        .pos      (pos_reg),
        .incr     (incr),
        .pos_step (pos_step),
        .in_block (in_block),
        .wrapped  (wrapped)
    );

    tbls_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BLOCK_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        prime_next    = prime_reg;
        root2_next    = root2_reg;
        weight_next   = weight_reg;
        hits_next     = hits_reg;
        hits1_next    = hits1_reg;
        next1_next    = next1_reg;
        root_sel_next = root_sel_reg;
        rd_hit_next   = rd_hit_reg;
        res_next      = res_reg;
        ram_wr_en     = 1'b0;
        ram_wr_data   = init_value;
        ram_rd_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next    = '0;
                    prime_next  = cmd.prime_value;
                    root2_next  = cmd.second_root;
                    weight_next = cmd.log_weight;
                    unique case (cmd.command)
                        CMD_CLEAR:
                        begin
                            pos_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        CMD_SIEVE:
                        begin
                            if (cmd.prime_value == '0)
                            begin
                                res_next.next_first_root  = cmd.first_root;
                                res_next.next_second_root = cmd.second_root;
                                res_next.skipped          = 1'b1;
                                state_next                = ST_DONE;
                            end
                            else
                            begin
                                pos_next      = {1'b0, cmd.first_root};
                                hits_next     = '0;
                                root_sel_next = 1'b0;
                                state_next    = ST_SV_RD;
                            end
                        end
                        CMD_READ:
                        begin
                            pos_next   = POS_W'(cmd.read_index);
                            state_next = ST_RD_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (in_block)
                begin
                    ram_wr_en = 1'b1;
                    pos_next  = pos_step;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SV_RD:
            begin
                if (in_block)
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_SV_WR;
                end
                else if (!root_sel_reg)
                begin
                    // First root finished; keep its result and start the second.
                    next1_next    = wrapped;
                    hits1_next    = hits_reg;
                    hits_next     = '0;
                    pos_next      = {1'b0, root2_reg};
                    root_sel_next = 1'b1;
                end
                else
                begin
                    if (hits1_reg > hits_reg)
                    begin
                        res_next.next_first_root  = wrapped;
                        res_next.next_second_root = next1_reg;
                    end
                    else
                    begin
                        res_next.next_first_root  = next1_reg;
                        res_next.next_second_root = wrapped;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SV_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data - weight_reg;
                pos_next    = pos_step;
                hits_next   = hits_reg + HIT_W'(1);
                state_next  = ST_SV_RD;
            end
            ST_RD_ADDR:
            begin
                ram_rd_en   = in_block;
                rd_hit_next = in_block;
                state_next  = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                res_next.read_byte = rd_hit_reg ? ram_rd_data : '0;
                state_next         = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        prime_reg    <= prime_next;
        root2_reg    <= root2_next;
        weight_reg   <= weight_next;
        hits_reg     <= hits_next;
        hits1_reg    <= hits1_next;
        next1_reg    <= next1_next;
        root_sel_reg <= root_sel_next;
        rd_hit_reg   <= rd_hit_next;
        res_reg      <= res_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// File: hw/rtl/two_root_block_log_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_root_block_log_sieve: byte log sieve of one block, two roots a prime
// Clears, sieves and reads a BLOCK_SIZE-byte sieve held in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                        Direction  Contents
//  --------  ---------------------------  ---------  ---------------------------
//  input     s_tvalid/s_tready/s_tdata/    in         command and one prime entry
//            s_tuser
//  output    m_tvalid/m_tready/m_tdata/    out        advanced roots, skip flag,
//            m_tuser                                  read byte
//  config    cfg_wr_en/cfg_wr_data         in         init_value register
//
// A clear word writes every byte of the block, one RAM write a cycle. In a
// sieve word each hit is a RAM read followed by a write-back, and the shared
// step unit advances the position once per hit. A read word passes through
// ST_RD_ADDR and ST_RD_DATA; a skipped entry goes straight to ST_DONE.
// The sieve RAM is not cleared by reset; it holds meaningful data only after
// a clear word. Reset empties the output register and zeroes init_value.
// The output register lets a new word be taken while a result still waits;
// the engine holds its next result until that register is free.
// ----------------------------------------------------------------------------
module two_root_block_log_sieve
    import tbls_pkg::*;
#(
    parameter int BLOCK_SIZE = 32768
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input words.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: prime_value[15:0], first_root[15:0], second_root[15:0],
    // log_weight[7:0], read_index[14:0], one zero pad bit.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // From bit 0: command[1:0].
    input  logic [CMD_W-1:0]      s_tuser,
    // Result words.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: next_first_root[15:0], next_second_root[15:0], read_byte[7:0].
    output logic [OUT_DATA_W-1:0] m_tdata,
    // From bit 0: skipped.
    output logic                  m_tuser,
    // Configuration: init_value.
    input  logic                  cfg_wr_en,
    input  logic [BYTE_W-1:0]     cfg_wr_data
);

    logic [BYTE_W-1:0] init_value_reg, init_value_next;
    logic              out_valid_reg,  out_valid_next;
    tbls_result_t      out_reg,        out_next;

    tbls_cmd_t    cmd;
    logic         eng_idle;
    logic         eng_res_valid;
    logic         eng_res_ready;
    tbls_result_t eng_res;
    logic         accept;

    // Unpack the incoming word into its fields.
    assign cmd.command     = s_tuser;
    assign cmd.prime_value = s_tdata[15:0];
    assign cmd.first_root  = s_tdata[31:16];
    assign cmd.second_root = s_tdata[47:32];
    assign cmd.log_weight  = s_tdata[55:48];
    assign cmd.read_index  = s_tdata[70:56];

    assign s_tready = eng_idle;
    assign accept   = s_tvalid && s_tready;

    // The output register may take a new result when empty or being drained.
    assign eng_res_ready = !out_valid_reg || m_tready;

    tbls_engine #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .cmd        (cmd),
        .init_value (init_value_reg),
        .idle       (eng_idle),
        .res_valid  (eng_res_valid),
        .res_ready  (eng_res_ready),
        .res        (eng_res)
    );

    always_comb
    begin
        init_value_next = cfg_wr_en ? cfg_wr_data : init_value_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            out_next       = eng_res;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            init_value_reg <= init_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.read_byte, out_reg.next_second_root,
                       out_reg.next_first_root};
    assign m_tuser  = out_reg.skipped;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the two-root block log sieve
// Drives clear, sieve and read words into the block over the input stream and
// checks every result word against a mirror of the sieve array that is kept
// here. Both stream sides idle and stall at random. The init value is
// reloaded between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import tbls_pkg::*;

    localparam int SIEVE_BYTES = 32768;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // A clear writes every byte of the block while most sieve words strike only a
    // small share of it, so a correct run stays well under the limit; the limit is
    // several times a correct run, with room for the long receiver hold-offs.
    localparam int CYCLE_LIMIT = 4000000;

    // Mirror of the sieve array and the queue of results still owed.
    class sieve_checker;
        logic [BYTE_W-1:0] mirror [SIEVE_BYTES];
        logic [BYTE_W-1:0] init_byte;
        tbls_result_t      pending_results [$];
        int                mismatches;

        function new();
            init_byte  = '0;
            mismatches = 0;
        endfunction

        // Subtracts the weight along one root's progression; returns its hits.
        function int unsigned strike(int unsigned root, int unsigned prime,
                                     logic [WEIGHT_W-1:0] weight);
            int unsigned pos;
            int unsigned hits;
            pos  = root;
            hits = 0;
            while (pos < SIEVE_BYTES) begin
                mirror[pos] = mirror[pos] - weight;
                hits++;
                pos += prime;
            end
            return hits;
        endfunction

        // Updates the mirror for one accepted word and queues its result.
        function void accept_word(tbls_cmd_t w);
            tbls_result_t r;
            int unsigned  hits_a;
            int unsigned  hits_b;
            int unsigned  adv_a;
            int unsigned  adv_b;
            r = '0;
            case (w.command)
                CMD_CLEAR:
                    foreach (mirror[i]) mirror[i] = init_byte;
                CMD_SIEVE:
                    if (w.prime_value == '0) begin
                        r.next_first_root  = w.first_root;
                        r.next_second_root = w.second_root;
                        r.skipped          = 1'b1;
                    end else begin
                        hits_a = strike(32'(w.first_root), 32'(w.prime_value),
                                        w.log_weight);
                        hits_b = strike(32'(w.second_root), 32'(w.prime_value),
                                        w.log_weight);
                        adv_a  = 32'(w.first_root) + hits_a * 32'(w.prime_value)
                                 - 32'(SIEVE_BYTES);
                        adv_b  = 32'(w.second_root) + hits_b * 32'(w.prime_value)
                                 - 32'(SIEVE_BYTES);
                        // The root that took more hits goes second.
                        if (hits_a > hits_b) begin
                            r.next_first_root  = adv_b[ROOT_W-1:0];
                            r.next_second_root = adv_a[ROOT_W-1:0];
                        end else begin
                            r.next_first_root  = adv_a[ROOT_W-1:0];
                            r.next_second_root = adv_b[ROOT_W-1:0];
                        end
                    end
                CMD_READ:
                    r.read_byte = mirror[w.read_index];
                default:
                    ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic flag);
            tbls_result_t got;
            tbls_result_t want;
            got.next_first_root  = data[15:0];
            got.next_second_root = data[31:16];
            got.read_byte        = data[39:32];
            got.skipped          = flag;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, data %h skipped %b",
                         $time, data, flag);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.next_first_root !== want.next_first_root
                || got.next_second_root !== want.next_second_root
                || got.skipped !== want.skipped
                || got.read_byte !== want.read_byte) begin
                $display("%0t: result mismatch, expected roots %h %h skip %b byte %h",
                         $time, want.next_first_root, want.next_second_root,
                         want.skipped, want.read_byte);
                $display("%0t:                  actual   roots %h %h skip %b byte %h",
                         $time, got.next_first_root, got.next_second_root,
                         got.skipped, got.read_byte);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // From bit 0: prime_value, first_root, second_root, log_weight,
    // read_index, one zero pad bit.
    logic [IN_DATA_W-1:0]  s_tdata;
    // From bit 0: command.
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // From bit 0: next_first_root, next_second_root, read_byte.
    logic [OUT_DATA_W-1:0] m_tdata;
    // From bit 0: skipped.
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [BYTE_W-1:0]     cfg_wr_data;

    sieve_checker  sieve_sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            rx_hold_request;
    int unsigned   cycle_count;
    logic [ROOT_W-1:0] recent_root;

    two_root_block_log_sieve #(
        .BLOCK_SIZE (SIEVE_BYTES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: a hung block must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus long hold-offs on request.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_request != 0) begin
                stall_left      = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Every word that leaves the block is checked at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            sieve_sb.check_result(m_tdata, m_tuser);
    end

    function automatic tbls_cmd_t make_word(logic [CMD_W-1:0] cmd,
                                            logic [ROOT_W-1:0] prime,
                                            logic [ROOT_W-1:0] root_a,
                                            logic [ROOT_W-1:0] root_b,
                                            logic [WEIGHT_W-1:0] weight,
                                            logic [INDEX_W-1:0] index);
        tbls_cmd_t w;
        w.command     = cmd;
        w.prime_value = prime;
        w.first_root  = root_a;
        w.second_root = root_b;
        w.log_weight  = weight;
        w.read_index  = index;
        return w;
    endfunction

    // Mostly sieve words with medium and large primes followed by reads that
    // often land on a recent root; small primes and clears are kept rare because
    // they take long.
    function automatic tbls_cmd_t random_word();
        tbls_cmd_t         w;
        int unsigned       pick;
        logic [ROOT_W-1:0] swap_root;
        w = make_word(CMD_SIEVE, ROOT_W'($urandom_range(16'hFFFF)),
                      ROOT_W'($urandom_range(16'hFFFF)),
                      ROOT_W'($urandom_range(16'hFFFF)),
                      WEIGHT_W'($urandom_range(8'hFF)),
                      INDEX_W'($urandom_range(15'h7FFF)));
        pick = $urandom_range(999);
        if (pick < 3) begin
            w.command = CMD_CLEAR;
        end else if (pick < 30) begin
            w.command = CMD_UNUSED;
        end else if (pick < 380) begin
            w.command = CMD_READ;
            if ($urandom_range(1) == 1)
                w.read_index = recent_root[INDEX_W-1:0];
        end else begin
            pick = $urandom_range(99);
            if (pick < 6)
                w.prime_value = '0;
            else if (pick < 9)
                w.prime_value = ROOT_W'($urandom_range(1023, 64));
            else if (pick < 30)
                w.prime_value = ROOT_W'($urandom_range(65535, 32768));
            else
                w.prime_value = ROOT_W'($urandom_range(32767, 1024));
            // Roots mostly inside the block, sometimes beyond it.
            if ($urandom_range(4) != 0) begin
                w.first_root  = ROOT_W'($urandom_range(SIEVE_BYTES - 1));
                w.second_root = ROOT_W'($urandom_range(SIEVE_BYTES - 1));
            end
            if ($urandom_range(1) == 1 && w.first_root > w.second_root) begin
                swap_root     = w.first_root;
                w.first_root  = w.second_root;
                w.second_root = swap_root;
            end
            if ($urandom_range(19) == 0)
                w.second_root = w.first_root;
            recent_root = ($urandom_range(1) == 1) ? w.first_root : w.second_root;
        end
        return w;
    endfunction

    // Offers one word, idling first at the sender's rate, and returns at the
    // edge that accepts it. The valid stays high for a back-to-back word.
    task automatic send_word(input tbls_cmd_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, w.read_index, w.log_weight, w.second_root,
                     w.first_root, w.prime_value};
        s_tuser  <= w.command;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sieve_sb.accept_word(w);
    endtask

    // Stops offering words and waits until every owed result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sieve_sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // The init value may only change while the block is idle.
    task automatic load_init_value(input logic [BYTE_W-1:0] value);
        drain_results();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sieve_sb.init_byte = value;
    endtask

    initial
    begin : stimulus
        sieve_sb        = new();
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = CMD_CLEAR;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        rx_hold_request = 0;
        cycle_count     = 0;
        recent_root     = '0;
        tx_idle_pct     = 26;
        rx_idle_pct     = 51;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the array is cleared before anything touches it.
        load_init_value(8'hFF);
        send_word(make_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h0000));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h0000));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h7FFF));
        // Prime zero: nothing sieved, roots passed through.
        send_word(make_word(CMD_SIEVE, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF, 15'h0000));
        // Largest prime: one hit per root.
        send_word(make_word(CMD_SIEVE, 16'hFFFF, 16'h0000, 16'h7FFF, 8'hFF, 15'h0000));
        // Both roots at or beyond the end of the block.
        send_word(make_word(CMD_SIEVE, 16'h0001, 16'h8000, 16'hFFFF, 8'h01, 15'h0000));
        // First root takes more hits, so the advanced roots are swapped.
        send_word(make_word(CMD_SIEVE, 16'h0001, 16'h7FF8, 16'h7FFD, 8'h03, 15'h0000));
        // Equal roots strike the same bytes twice.
        send_word(make_word(CMD_SIEVE, 16'd1000, 16'd5, 16'd5, 8'h80, 15'h0000));
        send_word(make_word(CMD_SIEVE, 16'd3000, 16'd1000, 16'd200, 8'h00, 15'h0000));
        // Second root beyond the block.
        send_word(make_word(CMD_SIEVE, 16'd5000, 16'd100, 16'd40000, 8'h11, 15'h0000));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd5));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd32760));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h7FFF));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd1000));
        // The unused command must answer all zeros whatever it carries.
        send_word(make_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 15'h7FFF));
        send_word(make_word(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'h0000));
        load_init_value(8'h00);
        send_word(make_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 15'h7FFF));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd12345));
        send_word(make_word(CMD_SIEVE, 16'd2, 16'd32700, 16'd32701, 8'h7F, 15'h0000));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd32700));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd32701));
        send_word(make_word(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, 15'd32766));

        // Random part: three idling patterns, two init values under each.
        for (int mode = 0; mode < 3; mode++) begin
            for (int pass = 0; pass < 2; pass++) begin
                load_init_value(BYTE_W'($urandom_range(8'hFF)));
                tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 51 : 0;
                rx_idle_pct = (mode == 0) ? 51 : (mode == 1) ? 26 : 0;
                send_word(make_word(CMD_CLEAR, ROOT_W'($urandom_range(16'hFFFF)),
                                    ROOT_W'($urandom_range(16'hFFFF)),
                                    ROOT_W'($urandom_range(16'hFFFF)),
                                    WEIGHT_W'($urandom_range(8'hFF)),
                                    INDEX_W'($urandom_range(15'h7FFF))));
                for (int n = 0; n < 205; n++) begin
                    // Long receiver hold-off while words keep coming, so the
                    // output register and the engine both fill and the input
                    // stalls.
                    if (n == 40)
                        rx_hold_request = 400;
                    // Sender pause until the block has returned everything.
                    if (n == 100)
                        drain_results();
                    send_word(random_word());
                end
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (sieve_sb.mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
